// ===== rtl/sflm_pkg.sv =====
// shared types, constants and helpers for the segregated free list manager
`default_nettype none

package sflm_pkg;

  localparam int NumClasses = 8;
  localparam int NumBlocks  = 256;
  localparam int SizeBits   = 16;
  localparam int NodeCount  = NumBlocks + NumClasses;
  localparam int NodeW      = $clog2(NodeCount);
  localparam int BlockW     = $clog2(NumBlocks);
  localparam int ClassW     = $clog2(NumClasses);

  typedef logic [NodeW-1:0]    node_t;
  typedef logic [BlockW-1:0]   block_t;
  typedef logic [ClassW-1:0]   class_t;
  typedef logic [SizeBits-1:0] size_t;

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeFind   = 2'd1,
    ModeRemove = 2'd2,
    ModeNop    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StInsLink,
    StInsHead,
    StRmWrite,
    StFdWalk,
    StFdCheck,
    StResp
  } state_e;

  typedef struct packed {
    mode_e        mode;
    block_t       block_id;
    logic [15:0]  block_size;
    class_t       size_class;
    logic [15:0]  request_size;
  } item_t;

  typedef struct packed {
    logic   found;
    block_t found_block;
    class_t found_class;
  } result_t;

  typedef struct packed {
    node_t raddr;
    logic  we;
    node_t waddr;
    node_t wdata;
  } link_req_t;

  typedef struct packed {
    block_t raddr;
    logic   we;
    block_t waddr;
    size_t  wdata;
  } size_req_t;

  function automatic node_t sentinel(input class_t cls);
    sentinel = node_t'(NumBlocks) + node_t'(cls);
  endfunction

  function automatic node_t block_node(input block_t blk);
    block_node = node_t'(blk);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sflm_ram.sv =====
// generic single write port ram with one registered read port
`default_nettype none

module sflm_ram #(
  parameter int Depth = 256,
  parameter int Width = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/sflm_ctrl.sv =====
// operation sequencer: listed bits, list walk and link read-modify-write
`default_nettype none

module sflm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sflm_pkg::item_t    in_item_i,
  input  wire sflm_pkg::node_t    next_rdata_i,
  input  wire sflm_pkg::node_t    prev_rdata_i,
  input  wire sflm_pkg::size_t    size_rdata_i,
  output sflm_pkg::link_req_t     next_req_o,
  output sflm_pkg::link_req_t     prev_req_o,
  output sflm_pkg::size_req_t     size_req_o,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output sflm_pkg::result_t       res_o
);

  sflm_pkg::state_e  state_q, state_d;
  sflm_pkg::item_t   item_q, item_d;
  sflm_pkg::class_t  cls_q, cls_d;
  sflm_pkg::node_t   node_q, node_d;
  sflm_pkg::class_t  init_cnt_q, init_cnt_d;
  sflm_pkg::result_t res_q, res_d;
  logic [sflm_pkg::NumBlocks-1:0] listed_q, listed_d;

  logic             accept;
  logic             fit;
  logic             cand_is_sent;
  logic             last_class;
  sflm_pkg::block_t node_blk;

  assign accept       = in_valid_i && (state_q == sflm_pkg::StIdle);
  assign node_blk     = node_q[sflm_pkg::BlockW-1:0];
  assign fit          = (state_q == sflm_pkg::StFdCheck) &&
                        (size_rdata_i >= item_q.request_size);
  assign cand_is_sent = (next_rdata_i >= sflm_pkg::node_t'(sflm_pkg::NumBlocks));
  assign last_class   = (cls_q == sflm_pkg::class_t'(sflm_pkg::NumClasses - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sflm_pkg::StInit: begin
        if (init_cnt_q == sflm_pkg::class_t'(sflm_pkg::NumClasses - 1)) begin
          state_d = sflm_pkg::StIdle;
        end
      end
      sflm_pkg::StIdle: begin
        if (accept) begin
          unique case (in_item_i.mode)
            sflm_pkg::ModeInsert: state_d = listed_q[in_item_i.block_id] ?
                                            sflm_pkg::StResp : sflm_pkg::StInsLink;
            sflm_pkg::ModeFind:   state_d = sflm_pkg::StFdWalk;
            sflm_pkg::ModeRemove: state_d = listed_q[in_item_i.block_id] ?
                                            sflm_pkg::StRmWrite : sflm_pkg::StResp;
            default:              state_d = sflm_pkg::StResp;
          endcase
        end
      end
      sflm_pkg::StInsLink: state_d = sflm_pkg::StInsHead;
      sflm_pkg::StInsHead: state_d = sflm_pkg::StResp;
      sflm_pkg::StRmWrite: state_d = sflm_pkg::StResp;
      sflm_pkg::StFdWalk, sflm_pkg::StFdCheck: begin
        if (fit) begin
          state_d = sflm_pkg::StResp;
        end else if (cand_is_sent) begin
          state_d = last_class ? sflm_pkg::StResp : sflm_pkg::StFdWalk;
        end else begin
          state_d = sflm_pkg::StFdCheck;
        end
      end
      sflm_pkg::StResp: begin
        if (res_ready_i) begin
          state_d = sflm_pkg::StIdle;
        end
      end
      default: state_d = sflm_pkg::StIdle;
    endcase
  end

  // memory requests and datapath
  always_comb begin
    next_req_o = '0;
    prev_req_o = '0;
    size_req_o = '0;
    item_d     = item_q;
    cls_d      = cls_q;
    node_d     = node_q;
    init_cnt_d = init_cnt_q;
    res_d      = res_q;
    listed_d   = listed_q;
    unique case (state_q)
      sflm_pkg::StInit: begin
        // sentinels start pointing at themselves
        next_req_o.we    = 1'b1;
        next_req_o.waddr = sflm_pkg::sentinel(init_cnt_q);
        next_req_o.wdata = sflm_pkg::sentinel(init_cnt_q);
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = sflm_pkg::sentinel(init_cnt_q);
        prev_req_o.wdata = sflm_pkg::sentinel(init_cnt_q);
        init_cnt_d       = init_cnt_q + 1'b1;
      end
      sflm_pkg::StIdle: begin
        if (in_item_i.mode == sflm_pkg::ModeRemove) begin
          next_req_o.raddr = sflm_pkg::block_node(in_item_i.block_id);
          prev_req_o.raddr = sflm_pkg::block_node(in_item_i.block_id);
        end else begin
          next_req_o.raddr = sflm_pkg::sentinel(in_item_i.size_class);
        end
        if (accept) begin
          item_d = in_item_i;
          cls_d  = in_item_i.size_class;
          res_d  = '0;
        end
      end
      sflm_pkg::StInsLink: begin
        node_d           = next_rdata_i;
        next_req_o.we    = 1'b1;
        next_req_o.waddr = sflm_pkg::sentinel(item_q.size_class);
        next_req_o.wdata = sflm_pkg::block_node(item_q.block_id);
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = sflm_pkg::block_node(item_q.block_id);
        prev_req_o.wdata = sflm_pkg::sentinel(item_q.size_class);
        size_req_o.we    = 1'b1;
        size_req_o.waddr = item_q.block_id;
        size_req_o.wdata = sflm_pkg::size_t'(item_q.block_size);
      end
      sflm_pkg::StInsHead: begin
        next_req_o.we    = 1'b1;
        next_req_o.waddr = sflm_pkg::block_node(item_q.block_id);
        next_req_o.wdata = node_q;
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = node_q;
        prev_req_o.wdata = sflm_pkg::block_node(item_q.block_id);
        listed_d[item_q.block_id] = 1'b1;
      end
      sflm_pkg::StRmWrite: begin
        next_req_o.we    = 1'b1;
        next_req_o.waddr = prev_rdata_i;
        next_req_o.wdata = next_rdata_i;
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = next_rdata_i;
        prev_req_o.wdata = prev_rdata_i;
        listed_d[item_q.block_id] = 1'b0;
      end
      sflm_pkg::StFdWalk, sflm_pkg::StFdCheck: begin
        if (fit) begin
          next_req_o.we    = 1'b1;
          next_req_o.waddr = prev_rdata_i;
          next_req_o.wdata = next_rdata_i;
          prev_req_o.we    = 1'b1;
          prev_req_o.waddr = next_rdata_i;
          prev_req_o.wdata = prev_rdata_i;
          listed_d[node_blk] = 1'b0;
          res_d.found        = 1'b1;
          res_d.found_block  = node_blk;
          res_d.found_class  = cls_q;
        end else if (cand_is_sent) begin
          // end of this class list, move to the next class head
          if (!last_class) begin
            cls_d            = cls_q + 1'b1;
            next_req_o.raddr = sflm_pkg::sentinel(cls_q + 1'b1);
          end
        end else begin
          node_d           = next_rdata_i;
          next_req_o.raddr = next_rdata_i;
          prev_req_o.raddr = next_rdata_i;
          size_req_o.raddr = next_rdata_i[sflm_pkg::BlockW-1:0];
        end
      end
      sflm_pkg::StResp: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sflm_pkg::StInit;
      init_cnt_q <= '0;
      listed_q   <= '0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      listed_q   <= listed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cls_q  <= cls_d;
    node_q <= node_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == sflm_pkg::StIdle);
  assign res_valid_o = (state_q == sflm_pkg::StResp);
  assign res_o       = res_q;

  // found block is no longer marked listed
  a_found_unlisted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sflm_pkg::StResp && res_q.found) |-> !listed_q[res_q.found_block])
    else $error("found block still listed");

  // an insert marks its block listed
  a_insert_lists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sflm_pkg::StInsHead) |=> listed_q[$past(item_q.block_id)])
    else $error("inserted block not listed");

  // search never goes below its starting class
  a_class_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sflm_pkg::StFdWalk || state_q == sflm_pkg::StFdCheck)
      |-> cls_q >= item_q.size_class)
    else $error("search class below start");

  // only find results may report found
  a_found_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sflm_pkg::StResp && res_q.found) |-> item_q.mode == sflm_pkg::ModeFind)
    else $error("found set outside find");

endmodule

`default_nettype wire

// ===== rtl/segregated_free_list_manager.sv =====
// top level of the segregated free list manager: link memories and result register
`default_nettype none

// Keeps one circular doubly linked free list per size class over a pool of block ids.
// Each transfer on the slave side is one operation: insert a block with its size at the
// head of a class, find the first block of at least the requested size searching from a
// class upward (and unlink it), or unlink a named block. Every operation gives exactly one
// result transfer; only find reports a non-zero result. After reset the block sets up the
// class sentinels before it takes the first item. Operations run one at a time, paced by
// the registered reads of the link memories: insert passes through StInsLink and StInsHead,
// remove through StRmWrite, a no-op or an ignored insert/remove goes straight to the result,
// and find takes one StFdWalk step per class head visited and one StFdCheck step per list
// node examined; each ends in the StResp state. The result sits in an output register, so
// the next item can be taken while the previous result waits on the master side.
module segregated_free_list_manager (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // block_id, block_size, size_class, request_size
  input  wire logic [1:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // found_block, found_class
  output logic [0:0]       m_axis_tuser   // found
);

  sflm_pkg::item_t     in_item;
  sflm_pkg::link_req_t next_req;
  sflm_pkg::link_req_t prev_req;
  sflm_pkg::size_req_t size_req;
  sflm_pkg::node_t     next_rdata;
  sflm_pkg::node_t     prev_rdata;
  sflm_pkg::size_t     size_rdata;
  sflm_pkg::result_t   res;
  logic                res_valid;
  logic                res_ready;
  logic                out_valid_q, out_valid_d;
  sflm_pkg::result_t   out_res_q, out_res_d;

  // unpack the slave transfer
  assign in_item.mode         = sflm_pkg::mode_e'(s_axis_tuser);
  assign in_item.block_id     = s_axis_tdata[7:0];
  assign in_item.block_size   = s_axis_tdata[23:8];
  assign in_item.size_class   = s_axis_tdata[26:24];
  assign in_item.request_size = s_axis_tdata[42:27];

  sflm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .next_rdata_i (next_rdata),
    .prev_rdata_i (prev_rdata),
    .size_rdata_i (size_rdata),
    .next_req_o   (next_req),
    .prev_req_o   (prev_req),
    .size_req_o   (size_req),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // forward links, sentinels included
  sflm_ram #(
    .Depth (sflm_pkg::NodeCount),
    .Width (sflm_pkg::NodeW)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_req.we),
    .waddr_i (next_req.waddr),
    .wdata_i (next_req.wdata),
    .raddr_i (next_req.raddr),
    .rdata_o (next_rdata)
  );

  // backward links, sentinels included
  sflm_ram #(
    .Depth (sflm_pkg::NodeCount),
    .Width (sflm_pkg::NodeW)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_req.we),
    .waddr_i (prev_req.waddr),
    .wdata_i (prev_req.wdata),
    .raddr_i (prev_req.raddr),
    .rdata_o (prev_rdata)
  );

  // block sizes, written on insert
  sflm_ram #(
    .Depth (sflm_pkg::NumBlocks),
    .Width (sflm_pkg::SizeBits)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_req.we),
    .waddr_i (size_req.waddr),
    .wdata_i (size_req.wdata),
    .raddr_i (size_req.raddr),
    .rdata_o (size_rdata)
  );

  // output register: free or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.found_class, out_res_q.found_block};
  assign m_axis_tuser  = out_res_q.found;

endmodule

`default_nettype wire

// ===== tb/segregated_free_list_manager_test.sv =====
// testbench for the segregated free list manager: first-fit free lists checked against a model
`default_nettype none

// expected results, one per operation, kept in order of acceptance
class free_list_board;
  sflm_pkg::result_t pending_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_item(sflm_pkg::result_t want);
    pending_q.push_back(want);
  endfunction

  // compare one result transfer with the oldest expectation
  task check_result(sflm_pkg::result_t got);
    sflm_pkg::result_t want;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %p", got));
      return;
    end
    want = pending_q.pop_front();
    if (got.found !== want.found)
      report_mismatch($sformatf("found %0d want %0d", got.found, want.found));
    if (got.found_block !== want.found_block)
      report_mismatch($sformatf("block %0d want %0d", got.found_block, want.found_block));
    if (got.found_class !== want.found_class)
      report_mismatch($sformatf("class %0d want %0d", got.found_class, want.found_class));
  endtask

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask
endclass

module segregated_free_list_manager_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sflm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // block_id, block_size, size_class, request_size
  logic [1:0]  s_axis_tuser = '0;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // found_block, found_class
  logic [0:0]  m_axis_tuser;        // found

  free_list_board board = new();
  bit stim_done = 1'b0;

  // predictor state: links per node, sizes and membership per block
  int unsigned nxt [NodeCount];
  int unsigned prv [NodeCount];
  logic [15:0] sizes [NumBlocks];
  bit on_list [NumBlocks];

  segregated_free_list_manager uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void unlink(int unsigned node);
    nxt[prv[node]] = nxt[node];
    prv[nxt[node]] = prv[node];
    if (node < NumBlocks) on_list[node] = 1'b0;
  endfunction

  // apply one operation to the predictor and return its result
  function automatic result_t predict_op(mode_e md, int unsigned id, logic [15:0] bsz,
                                         int unsigned cls, logic [15:0] req);
    result_t r;
    int unsigned s, node;
    r = '0;
    case (md)
      ModeInsert: begin
        if (!on_list[id]) begin
          s = NumBlocks + cls;
          sizes[id] = bsz;
          nxt[id] = nxt[s];
          prv[id] = s;
          prv[nxt[s]] = id;
          nxt[s] = id;
          on_list[id] = 1'b1;
        end
      end
      ModeFind: begin
        for (int c = cls; c < NumClasses; c++) begin
          s = NumBlocks + c;
          node = nxt[s];
          while (node != s) begin
            if (sizes[node] >= req) begin
              unlink(node);
              r.found = 1'b1;
              r.found_block = block_t'(node);
              r.found_class = class_t'(c);
              return r;
            end
            node = nxt[node];
          end
        end
      end
      ModeRemove: if (on_list[id]) unlink(id);
      default: ;
    endcase
    return r;
  endfunction

  // gap length: mostly short, sometimes long, sometimes none
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one slave-side transfer; the expectation is noted at acceptance
  task automatic send_op(mode_e md, int unsigned id, logic [15:0] bsz,
                         int unsigned cls, logic [15:0] req);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= {5'b0, req, class_t'(cls), bsz, block_t'(id)};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(predict_op(md, id, bsz, cls, req));
  endtask

  // receiver: random stalls, checks each result transfer
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(result_t'({m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8]}));
      if (gap_len() == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int unsigned id;
    mode_e md;
    for (int i = 0; i < NodeCount; i++) begin
      nxt[i] = i;
      prv[i] = i;
    end
    for (int i = 0; i < NumBlocks; i++) on_list[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every mode, ignored insert/remove, out-of-reach request
    send_op(ModeFind, 0, 0, 0, 16'h0000);             // empty lists
    send_op(ModeInsert, 0, 16'h0000, 0, 0);
    send_op(ModeInsert, 255, 16'hffff, 7, 16'hffff);
    send_op(ModeInsert, 255, 16'h0001, 3, 0);          // already listed, ignored
    send_op(ModeInsert, 17, 16'h00aa, 0, 0);
    send_op(ModeInsert, 18, 16'h5555, 0, 0);
    send_op(ModeNop, 255, 16'hffff, 7, 16'hffff);
    send_op(ModeFind, 0, 0, 0, 16'h0100);              // takes head block 18
    send_op(ModeFind, 0, 0, 7, 16'hffff);              // top class, max size
    send_op(ModeFind, 0, 0, 1, 16'hffff);              // nothing left
    send_op(ModeRemove, 40, 0, 0, 0);                  // unlisted, ignored
    send_op(ModeRemove, 17, 0, 0, 0);
    send_op(ModeFind, 0, 0, 0, 16'h0000);              // takes block 0
    send_op(ModeFind, 0, 0, 0, 16'h0000);              // empty again

    // random: mostly valid inserts/finds/removes over a working set
    for (int n = 0; n < 1700; n++) begin
      id = $urandom_range(0, 99) < 85 ? $urandom_range(0, 31) : $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: md = ModeInsert;
        4, 5, 6:    md = ModeFind;
        7, 8:       md = ModeRemove;
        default:    md = ModeNop;
      endcase
      send_op(md, id, 16'($urandom()), $urandom_range(0, 7),
              ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000)));
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run: wait for all results, then drain
  initial begin
    wait (stim_done);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ===== segregated_free_list_manager.f =====
rtl/sflm_pkg.sv
rtl/sflm_ram.sv
rtl/sflm_ctrl.sv
rtl/segregated_free_list_manager.sv
tb/segregated_free_list_manager_test.sv
